[rtl/core/sts_pkg.sv]
`timescale 1ns / 1ps
package sts_pkg;

  localparam int MAX_TERMS = 16;

  // angle input, degrees with 6 fraction bits
  localparam int ANG_W = 16;
  localparam int ANGLE_LIMIT = 23040;
  localparam int AMAG_W = 15;

  // degrees to radians: round(pi/180 * 2^32), result rescaled to Q28
  localparam longint DEG2RAD_Q32 = 74961321;
  localparam int K_W = 27;
  localparam int CONV_SHIFT = 10;
  localparam longint CONV_RND = 512;

  // Q28 datapath
  localparam int FRAC = 28;
  localparam longint RND_HALF = 64'd1 << (FRAC - 1);
  localparam int XM_W = 31;
  localparam int X2_W = 34;
  localparam int X2L_W = 17;
  localparam int MAG_W = 35;
  localparam int SUM_W = 37;
  localparam int T_W = 41;
  localparam int QE_W = T_W - 2;
  localparam int RCP_W = T_W - 2;
  localparam int RL_W = 20;
  localparam int D_W = $clog2((2 * MAX_TERMS) * (2 * MAX_TERMS + 1) + 1);

  // configuration
  localparam int THR_W = 16;
  localparam int THR_SHIFT = FRAC - 16;
  localparam int LIM_W = THR_W + THR_SHIFT;
  localparam logic [THR_W-1:0] THR_RESET = 16'd7;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_THRESHOLD = 1'b0;

  // result
  localparam int SINE_W = 18;
  localparam int STEPS_W = 5;
  localparam int OUT_SHIFT = FRAC - 16;
  localparam longint ROUND_Q16 = 64'd1 << (OUT_SHIFT - 1);
  localparam longint SINE_ONE = 65536;

  // pipeline depth
  localparam int FRONT_LAT = 3;
  localparam int TERM_LAT = 5;
  localparam int LAT = FRONT_LAT + TERM_LAT * MAX_TERMS + 1;

  typedef struct packed {
    logic                    vld;
    logic                    done;
    logic                    trunc;
    logic                    neg;
    logic [STEPS_W-1:0]      steps;
    logic [MAG_W-1:0]        mag;
    logic [X2_W-1:0]         x2;
    logic signed [SUM_W-1:0] sum;
  } term_t;

  // per-stage constants of one series term
  typedef struct packed {
    logic [D_W-1:0]     dvsr;
    logic [RCP_W-1:0]   recip;
    logic [STEPS_W-1:0] steps;
    logic               last;
  } stage_cfg_t;

endpackage

[rtl/core/sts_front.sv]
`timescale 1ns / 1ps
module sts_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             take,
  input  logic signed [sts_pkg::ANG_W-1:0] angle_deg,
  output sts_pkg::term_t                   term_out
);
  import sts_pkg::*;

  localparam int CP_W = AMAG_W + K_W;
  localparam int SQ_W = 2 * XM_W;
  localparam logic signed [ANG_W-1:0] ANG_MAX = ANG_W'(ANGLE_LIMIT);
  localparam logic signed [ANG_W-1:0] ANG_MIN = -ANG_W'(ANGLE_LIMIT);

  logic signed [ANG_W-1:0] ang_sat;
  logic [AMAG_W-1:0] amag_next;
  logic [CP_W-1:0] cp2;
  logic [XM_W-1:0] xm_next;
  logic [SQ_W-1:0] sq3;

  logic v1, v2;
  logic neg1, neg2;
  logic [AMAG_W-1:0] amag1;
  logic [XM_W-1:0] xm2;

  always_comb begin
    if (angle_deg > ANG_MAX) begin
      ang_sat = ANG_MAX;
    end else if (angle_deg < ANG_MIN) begin
      ang_sat = ANG_MIN;
    end else begin
      ang_sat = angle_deg;
    end
    amag_next = ang_sat[ANG_W-1] ? AMAG_W'(-ang_sat) : AMAG_W'(ang_sat);
  end

  assign cp2 = CP_W'(amag1) * CP_W'(DEG2RAD_Q32) + CP_W'(CONV_RND);
  assign xm_next = XM_W'(cp2 >> CONV_SHIFT);
  assign sq3 = SQ_W'(xm2) * SQ_W'(xm2) + SQ_W'(RND_HALF);

  always_ff @(posedge clk) begin
    neg1  <= ang_sat[ANG_W-1];
    amag1 <= amag_next;
    neg2  <= neg1;
    xm2   <= xm_next;

    term_out.done  <= 1'b0;
    term_out.trunc <= 1'b0;
    term_out.neg   <= neg2;
    term_out.steps <= '0;
    term_out.mag   <= MAG_W'(xm2);
    term_out.x2    <= X2_W'(sq3 >> FRAC);
    term_out.sum   <= '0;

    v1           <= take;
    v2           <= v1;
    term_out.vld <= v2;
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      term_out.vld <= 1'b0;
    end
  end

endmodule

[rtl/core/sts_term.sv]
`timescale 1ns / 1ps
module sts_term (
  input  logic                         clk,
  input  logic                         rst,
  input  sts_pkg::stage_cfg_t          scfg,
  input  logic [sts_pkg::LIM_W-1:0]    limit,
  input  sts_pkg::term_t               term_in,
  output sts_pkg::term_t               term_out
);
  import sts_pkg::*;

  localparam int PL_W = MAG_W + X2L_W;
  localparam int ACC_W = PL_W + 1;
  localparam int PR_W = T_W + RL_W;
  localparam int QD_W = QE_W + D_W;

  term_t a1, a2, a3, a4;
  term_t a1_next, out_next;

  logic [PL_W-1:0] pl1;
  logic [T_W-1:0] t2, t3, t4;
  logic [PR_W-1:0] pr3;
  logic [QE_W-1:0] qe4;

  logic [ACC_W-1:0] acc2;
  logic [T_W-1:0] t2_next;
  logic [PR_W-1:0] qs4;
  logic [QD_W-1:0] qd5;
  logic [T_W-1:0] rem5;
  logic [QE_W-1:0] q5;
  logic conv5;

  // stage 1: accumulate the current term, low half of term * x^2
  always_comb begin
    a1_next = term_in;
    if (!term_in.done) begin
      if (term_in.neg) begin
        a1_next.sum = term_in.sum - $signed(SUM_W'(term_in.mag));
      end else begin
        a1_next.sum = term_in.sum + $signed(SUM_W'(term_in.mag));
      end
    end
  end

  // stage 2: high half, round to Q28, add d/2 for the rounded divide
  assign acc2 = ACC_W'(a1.mag) * ACC_W'(a1.x2[X2_W-1:X2L_W])
              + ((ACC_W'(pl1) + ACC_W'(RND_HALF)) >> X2L_W);
  assign t2_next = T_W'(acc2 >> (FRAC - X2L_W)) + T_W'(scfg.dvsr >> 1);

  // stage 4: quotient estimate from reciprocal, low by at most one
  assign qs4 = PR_W'(t3) * PR_W'(scfg.recip[RCP_W-1:RL_W]) + (pr3 >> RL_W);

  // stage 5: remainder check fixes the estimate
  always_comb begin
    qd5   = QD_W'(qe4) * QD_W'(scfg.dvsr);
    rem5  = t4 - T_W'(qd5);
    q5    = (rem5 >= T_W'(scfg.dvsr)) ? qe4 + QE_W'(1) : qe4;
    conv5 = q5 <= QE_W'(limit);

    out_next     = a4;
    out_next.mag = MAG_W'(q5);
    if (!a4.done) begin
      out_next.neg   = ~a4.neg;
      out_next.done  = conv5 | scfg.last;
      out_next.trunc = ~conv5 & scfg.last;
      out_next.steps = scfg.steps;
    end
  end

  always_ff @(posedge clk) begin
    a1  <= a1_next;
    pl1 <= PL_W'(term_in.mag) * PL_W'(term_in.x2[X2L_W-1:0]);
    a2  <= a1;
    t2  <= t2_next;
    a3  <= a2;
    t3  <= t2;
    pr3 <= PR_W'(t2) * PR_W'(scfg.recip[RL_W-1:0]);
    a4  <= a3;
    t4  <= t3;
    qe4 <= QE_W'(qs4 >> (T_W - RL_W));
    term_out <= out_next;
    if (rst) begin
      a1.vld       <= 1'b0;
      a2.vld       <= 1'b0;
      a3.vld       <= 1'b0;
      a4.vld       <= 1'b0;
      term_out.vld <= 1'b0;
    end
  end

endmodule

[rtl/core/sts_out.sv]
`timescale 1ns / 1ps
module sts_out (
  input  logic                              clk,
  input  logic                              rst,
  input  sts_pkg::term_t                    term_in,
  output logic                              done,
  output logic signed [sts_pkg::SINE_W-1:0] sine_value,
  output logic [sts_pkg::STEPS_W-1:0]       steps,
  output logic                              truncated
);
  import sts_pkg::*;

  localparam int SM_W = SUM_W + 1;
  localparam int RND_W = SM_W - OUT_SHIFT;

  logic [SUM_W-1:0] sm;
  logic [RND_W-1:0] r, rs;
  logic [SINE_W-1:0] sine_next;

  always_comb begin
    sm = term_in.sum[SUM_W-1] ? SUM_W'(-term_in.sum) : SUM_W'(term_in.sum);
    r  = RND_W'((SM_W'(sm) + SM_W'(ROUND_Q16)) >> OUT_SHIFT);
    rs = (r > RND_W'(SINE_ONE)) ? RND_W'(SINE_ONE) : r;
    sine_next = term_in.sum[SUM_W-1] ? -SINE_W'(rs) : SINE_W'(rs);
  end

  always_ff @(posedge clk) begin
    sine_value <= sine_next;
    steps      <= term_in.steps;
    truncated  <= term_in.trunc;
    done       <= term_in.vld;
    if (rst) begin
      done <= 1'b0;
    end
  end

endmodule

[rtl/core/sine_taylor_series.sv]
`timescale 1ns / 1ps
// channel   signals                            word
// ------    ---------------------------------  ----------------------------------
// angle     start, busy, angle_deg             taken when start & !busy
// result    done, sine_value, steps, truncated one word per done strobe
// config    APB psel/penable/pwrite/paddr/...  term_threshold at 0x0-0x3
//
// Fully pipelined: one angle per cycle outside reset, passing through
// 3 front stages, 5 stages per series term times 16 terms, 1 output stage.
// The term loop is unrolled; each term stage is multiply, reciprocal divide
// and remainder fix. Past convergence, words keep their sum and step count.
// busy is high only during reset. The result side cannot stall; done is
// asserted for exactly one cycle per word and words come out in order.
module sine_taylor_series (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [sts_pkg::ANG_W-1:0]      angle_deg,
  output logic                                  done,
  output logic signed [sts_pkg::SINE_W-1:0]     sine_value,
  output logic [sts_pkg::STEPS_W-1:0]           steps,
  output logic                                  truncated,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [sts_pkg::CFG_ADDR_W-1:0]        paddr,
  input  logic [sts_pkg::CFG_DATA_W-1:0]        pwdata,
  output logic [sts_pkg::CFG_DATA_W-1:0]        prdata,
  output logic                                  pready
);
  import sts_pkg::*;

  logic [THR_W-1:0] term_threshold;
  logic [LIM_W-1:0] limit;
  logic take;
  logic sel_thr;

  term_t chain [MAX_TERMS+1];

  assign busy    = rst;
  assign take    = start & ~busy;
  assign pready  = 1'b1;
  assign sel_thr = paddr[CFG_ADDR_W-1] == REG_THRESHOLD;
  assign prdata  = sel_thr ? CFG_DATA_W'(term_threshold) : '0;
  assign limit   = {term_threshold, {THR_SHIFT{1'b0}}};

  always_ff @(posedge clk) begin
    if (psel && penable && pwrite && pready && sel_thr) begin
      term_threshold <= pwdata[THR_W-1:0];
    end
    if (rst) begin
      term_threshold <= THR_RESET;
    end
  end

  sts_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .angle_deg (angle_deg),
    .term_out  (chain[0])
  );

  for (genvar gi = 0; gi < MAX_TERMS; gi++) begin : g_term
    localparam int DV = (2 * gi + 2) * (2 * gi + 3);
    localparam longint unsigned RCP = (64'd1 << T_W) / DV;
    stage_cfg_t scfg;

    assign scfg.dvsr  = D_W'(DV);
    assign scfg.recip = RCP_W'(RCP);
    assign scfg.steps = STEPS_W'(gi + 2);
    assign scfg.last  = (gi == MAX_TERMS - 1);

    sts_term u_term (
      .clk      (clk),
      .rst      (rst),
      .scfg     (scfg),
      .limit    (limit),
      .term_in  (chain[gi]),
      .term_out (chain[gi+1])
    );
  end

  sts_out u_out (
    .clk        (clk),
    .rst        (rst),
    .term_in    (chain[MAX_TERMS]),
    .done       (done),
    .sine_value (sine_value),
    .steps      (steps),
    .truncated  (truncated)
  );

  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result word without a matching accepted angle");

  a_trunc_steps: assert property (@(posedge clk) disable iff (rst)
    done && truncated |-> steps == STEPS_W'(MAX_TERMS + 1))
    else $error("truncated result with wrong step count");

  a_sine_range: assert property (@(posedge clk) disable iff (rst)
    done |-> sine_value <= SINE_W'(SINE_ONE) && sine_value >= -SINE_W'(SINE_ONE))
    else $error("sine out of range");

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import sts_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] ADDR_THRESHOLD = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] ADDR_SPARE = 3'd4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic signed [SINE_W-1:0] sine;
    logic [STEPS_W-1:0]       steps;
    logic                     truncated;
  } sine_word_t;

  logic                         clk;
  logic                         rst;
  logic                         start;
  logic                         busy;
  logic signed [ANG_W-1:0]      angle_deg;
  logic                         done;
  logic signed [SINE_W-1:0]     sine_value;
  logic [STEPS_W-1:0]           steps;
  logic                         truncated;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [CFG_ADDR_W-1:0]        paddr;
  logic [CFG_DATA_W-1:0]        pwdata;
  logic [CFG_DATA_W-1:0]        prdata;
  logic                         pready;

  sine_word_t  pending_sines[$];
  sine_word_t  head_word;
  logic [15:0] threshold_q16;
  int          sender_idle_pct;
  int          mismatches;
  int          cycle_count;

  sine_taylor_series DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .angle_deg(angle_deg),
    .done(done), .sine_value(sine_value), .steps(steps), .truncated(truncated),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // rounded Q28 product, split so no partial product overflows 64 bits
  function automatic longint unsigned q28_product(longint unsigned a, longint unsigned b);
    longint unsigned hi_part;
    longint unsigned lo_part;
    hi_part = b >> 14;
    lo_part = a * (b & 64'h3FFF) + (64'd1 << 27);
    return (a * hi_part + (lo_part >> 14)) >> 14;
  endfunction

  function automatic sine_word_t predict_sine(logic signed [ANG_W-1:0] angle,
                                              logic [15:0] thr);
    longint          ang;
    bit              neg;
    bit              stop;
    bit              trunc;
    longint unsigned amag, xm, x2, mag, lim, d, sm, r, signed_r;
    longint          sum;
    int              k;
    sine_word_t      w;
    ang = angle;
    if (ang > ANGLE_LIMIT) ang = ANGLE_LIMIT;
    if (ang < -ANGLE_LIMIT) ang = -ANGLE_LIMIT;
    neg = ang < 0;
    amag = neg ? -ang : ang;
    xm = (amag * DEG2RAD_Q32 + 64'd512) >> 10;
    x2 = q28_product(xm, xm);
    lim = longint'(thr) << 12;
    mag = xm;
    sum = 0;
    k = 0;
    stop = 1'b0;
    trunc = 1'b0;
    while (!stop) begin
      d = (2 * k + 2) * (2 * k + 3);
      sum = neg ? sum - longint'(mag) : sum + longint'(mag);
      mag = q28_product(mag, x2);
      mag = (mag + d / 2) / d;
      neg = !neg;
      k++;
      if (mag <= lim) begin
        stop = 1'b1;
      end else if (k >= MAX_TERMS) begin
        trunc = 1'b1;
        stop = 1'b1;
      end
    end
    sm = (sum < 0) ? -sum : sum;
    r = (sm + 64'd2048) >> 12;
    if (r > 64'd65536) r = 64'd65536;
    signed_r = (sum < 0) ? (64'd0 - r) : r;
    w.sine = signed_r[SINE_W-1:0];
    w.steps = STEPS_W'(k + 1);
    w.truncated = trunc;
    return w;
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_SHOWN)
      $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // one word per done strobe, compared against the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_sines.size() == 0) begin
        note_mismatch($sformatf("unexpected word sine=%0d steps=%0d trunc=%0b",
                                sine_value, steps, truncated));
      end else begin
        head_word = pending_sines.pop_front();
        if (head_word.sine !== sine_value || head_word.steps !== steps ||
            head_word.truncated !== truncated)
          note_mismatch($sformatf(
              "exp sine=%0d steps=%0d trunc=%0b, got sine=%0d steps=%0d trunc=%0b",
              head_word.sine, head_word.steps, head_word.truncated,
              sine_value, steps, truncated));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_angle(input logic signed [ANG_W-1:0] angle);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    angle_deg <= angle;
    do @(posedge clk); while (busy);
    pending_sines.push_back(predict_sine(angle, threshold_q16));
  endtask

  // only while the pipeline is empty
  task automatic write_cfg(input logic [CFG_ADDR_W-1:0] addr, input logic [15:0] value);
    start <= 1'b0;
    while (pending_sines.size() != 0) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_THRESHOLD)
      threshold_q16 = value;
  endtask

  task automatic test_reset_threshold();
    send_angle(0);
    send_angle(1);
    send_angle(-1);
    send_angle(64);
    send_angle(2880);
    send_angle(5760);
    send_angle(-5760);
    send_angle(11520);
    send_angle(17280);
    send_angle(23040);
    send_angle(-23040);
    // beyond +/-360 degrees, saturated
    send_angle(23041);
    send_angle(-23041);
    send_angle(16'sh7FFF);
    send_angle(-16'sh8000);
  endtask

  task automatic test_threshold_extremes();
    // zero threshold: runs until a term rounds to zero
    write_cfg(ADDR_THRESHOLD, 16'h0000);
    send_angle(23040);
    send_angle(-23040);
    send_angle(11520);
    send_angle(1);
    send_angle(0);
    write_cfg(ADDR_THRESHOLD, 16'hFFFF);
    send_angle(23040);
    send_angle(64);
    send_angle(0);
    send_angle(-5760);
  endtask

  task automatic test_unmapped_write();
    // write past the last register must leave the threshold alone
    write_cfg(ADDR_SPARE, 16'h0000);
    send_angle(23040);
    send_angle(-11520);
  endtask

  task automatic test_random_angles();
    int idle_by_phase[4];
    logic signed [ANG_W-1:0] a;
    idle_by_phase = '{0, 71, 0, 25};
    for (int p = 0; p < 8; p++) begin
      sender_idle_pct = 0;
      write_cfg(ADDR_THRESHOLD, (p % 2 == 0) ? 16'($urandom_range(0, 63))
                                             : 16'($urandom_range(0, 65535)));
      sender_idle_pct = idle_by_phase[p % 4];
      for (int i = 0; i < 170; i++) begin
        case ($urandom_range(9))
          0: a = ANG_W'($urandom);
          1: a = ANG_W'(int'($urandom_range(0, 256)) - 128);
          default: a = ANG_W'(int'($urandom_range(0, 2 * ANGLE_LIMIT)) - ANGLE_LIMIT);
        endcase
        send_angle(a);
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    angle_deg <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    threshold_q16 = THR_RESET;
    sender_idle_pct = 0;
    mismatches = 0;
    cycle_count = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_reset_threshold();
    test_threshold_extremes();
    test_unmapped_write();
    test_random_angles();

    start <= 1'b0;
    while (pending_sines.size() != 0) @(posedge clk);
    repeat (LAT + 16) @(posedge clk);
    if (mismatches == 0 && pending_sines.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
